/* src/assert_macros.svh */
// Assertion shorthands shared by the speed meter RTL.
// Expects clk_i and rst_ni in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define CPSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define CPSM_NEVER(lbl, cond, msg) \
  `CPSM_ASSERT(lbl, !(cond), msg)

`endif

/* src/cpsm_pkg.sv */
// Shared types and constants of the capture-period speed meter.
// No dependencies; imported by the interfaces and all modules.
package cpsm_pkg;

  localparam int unsigned CAP_W     = 32;  // capture field width
  localparam int unsigned NUM_W     = 24;  // speed numerator width
  localparam int unsigned TMO_W     = 16;  // timeout / idle counter width
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned MAG_W     = 15;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam int unsigned BUFFER_SLOTS_DEF = 2;
  localparam int unsigned COUNTER_BITS_DEF = 32;

  localparam logic [NUM_W-1:0] NUM_RESET     = NUM_W'(240000);
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(1000);
  localparam logic [MAG_W-1:0] SPEED_MAX     = '1;

  // item kinds
  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // register indexes (paddr[2])
  localparam logic REG_NUMERATOR = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  typedef struct packed {
    logic [NUM_W-1:0] speed_numerator;
    logic [TMO_W-1:0] timeout_ticks;
  } cfg_t;

endpackage

/* src/cpsm_if.sv */
// Valid/ready channel interfaces for capture/tick items and speed results.
// Depends on cpsm_pkg.
interface cpsm_in_if import cpsm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [CAP_W-1:0] capture_value;
  logic             direction_reverse;

  modport source (output valid, req_type, capture_value, direction_reverse, input ready);
  modport sink   (input valid, req_type, capture_value, direction_reverse, output ready);
endinterface

interface cpsm_out_if import cpsm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_mrev_s;
  logic                      slot_index;
  logic                      from_timeout;
  logic                      clipped;

  modport source (output valid, speed_mrev_s, slot_index, from_timeout, clipped, input ready);
  modport sink   (input valid, speed_mrev_s, slot_index, from_timeout, clipped, output ready);
endinterface

/* src/capture_period_speed_meter.sv */
// Capture-period speed meter: top level with the item sequencer.
// Depends on cpsm_pkg, cpsm_if, cpsm_divider, cpsm_regs, assert_macros.svh.
//
// A capture item goes from transfer through the one-bit-per-cycle divider
// (NUM_W quotient bits), is saturated and signed once the divider flags
// done, is held in the pending register, and is then loaded into the
// output register. A capture with zero period and a tick item that hits the
// timeout skip the divider; a tick below the timeout gives none and the
// block is ready again in the next cycle. The input is not ready while an
// item is in flight; a finished result sits in the output register, so the
// next item can be taken before it is consumed, and a following result
// waits only if that register is still full.
`include "assert_macros.svh"

module capture_period_speed_meter import cpsm_pkg::*; #(
  parameter int unsigned BUFFER_SLOTS = BUFFER_SLOTS_DEF,
  parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cpsm_in_if.sink           in_i,
  cpsm_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned SLOT_W = $clog2(BUFFER_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  cfg_t cfg;

  logic [1:0]              state_q, state_d;
  logic [COUNTER_BITS-1:0] prev_q, prev_d;
  logic [TMO_W-1:0]        idle_q, idle_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic                    rev_q, rev_d;
  logic [SPEED_W-1:0]      pend_speed_q, pend_speed_d;
  logic                    pend_tmo_q, pend_tmo_d;
  logic                    pend_clip_q, pend_clip_d;

  logic                    out_valid_q, out_valid_d;
  logic [SPEED_W-1:0]      out_speed_q, out_speed_d;
  logic                    out_slot_q, out_slot_d;
  logic                    out_tmo_q, out_tmo_d;
  logic                    out_clip_q, out_clip_d;

  logic                    in_xfer, out_free;
  logic [COUNTER_BITS-1:0] cap, diff;
  logic [TMO_W-1:0]        idle_inc;
  logic                    div_start, div_busy, div_done;
  logic [NUM_W-1:0]        quotient;
  logic                    q_clip;
  logic [MAG_W-1:0]        mag;
  logic [SPEED_W-1:0]      signed_mag;

  cpsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cpsm_divider #(.DIV_W(COUNTER_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cfg.speed_numerator),
    .divisor_i  (diff),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign cap      = in_i.capture_value[COUNTER_BITS-1:0];
  assign diff     = cap - prev_q;
  assign idle_inc = (idle_q == '1) ? idle_q : idle_q + 1'b1;

  assign div_start = in_xfer && (in_i.req_type == REQ_CAPTURE) && (diff != '0);

  assign q_clip     = |quotient[NUM_W-1:MAG_W];
  assign mag        = q_clip ? SPEED_MAX : quotient[MAG_W-1:0];
  assign signed_mag = rev_q ? (SPEED_W'(0) - {1'b0, mag}) : {1'b0, mag};

  always_comb begin
    state_d      = state_q;
    prev_d       = prev_q;
    idle_d       = idle_q;
    slot_d       = slot_q;
    rev_d        = rev_q;
    pend_speed_d = pend_speed_q;
    pend_tmo_d   = pend_tmo_q;
    pend_clip_d  = pend_clip_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_speed_d  = out_speed_q;
    out_slot_d   = out_slot_q;
    out_tmo_d    = out_tmo_q;
    out_clip_d   = out_clip_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_i.req_type == REQ_CAPTURE) begin
            prev_d       = cap;
            idle_d       = '0;
            rev_d        = in_i.direction_reverse;
            pend_speed_d = '0;
            pend_tmo_d   = 1'b0;
            pend_clip_d  = 1'b0;
            state_d      = (diff == '0) ? S_EMIT : S_DIV;
          end else if (idle_inc > cfg.timeout_ticks) begin
            idle_d       = '0;
            pend_speed_d = '0;
            pend_tmo_d   = 1'b1;
            pend_clip_d  = 1'b0;
            state_d      = S_EMIT;
          end else begin
            idle_d = idle_inc;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          pend_speed_d = signed_mag;
          pend_clip_d  = q_clip;
          state_d      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_speed_d = pend_speed_q;
          out_slot_d  = slot_q[0];
          out_tmo_d   = pend_tmo_q;
          out_clip_d  = pend_clip_q;
          slot_d      = (slot_q == SLOT_W'(BUFFER_SLOTS - 1)) ? '0 : slot_q + 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      idle_q      <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      idle_q      <= idle_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rev_q        <= rev_d;
    pend_speed_q <= pend_speed_d;
    pend_tmo_q   <= pend_tmo_d;
    pend_clip_q  <= pend_clip_d;
    out_speed_q  <= out_speed_d;
    out_slot_q   <= out_slot_d;
    out_tmo_q    <= out_tmo_d;
    out_clip_q   <= out_clip_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.speed_mrev_s = out_speed_q;
  assign out_o.slot_index   = out_slot_q;
  assign out_o.from_timeout = out_tmo_q;
  assign out_o.clipped      = out_clip_q;

  `CPSM_ASSERT(a_done_in_div, div_done |-> state_q == S_DIV, "divider result outside divide")
  `CPSM_ASSERT(a_div_state_busy, state_q == S_DIV && !div_done |-> div_busy,
               "waiting on an idle divider")
  `CPSM_ASSERT(a_timeout_zero, out_valid_q && out_tmo_q |-> out_speed_q == '0 && !out_clip_q,
               "timeout result not a plain zero")
  `CPSM_ASSERT(a_clip_full, out_valid_q && out_clip_q |->
               out_speed_q == 16'h7fff || out_speed_q == 16'h8001,
               "clipped result not at full scale")

endmodule

/* src/cpsm_divider.sv */
// Restoring divider, one quotient bit per cycle, NUM_W quotient bits per division.
// Depends on cpsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpsm_divider import cpsm_pkg::*; #(
  parameter int unsigned DIV_W = COUNTER_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W:0]   rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;   // dividend bits shift out, quotient bits shift in
  logic [DIV_W-1:0] div_q, div_d;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem_q[DIV_W-1:0], quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (trial - {1'b0, div_q}) : trial;
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `CPSM_ASSERT(a_done_after_busy, done_o |-> $past(busy_q), "divider done without a run")
  `CPSM_NEVER(a_start_while_busy, start_i && busy_q, "divider restarted mid-run")
  `CPSM_ASSERT(a_rem_below_div, busy_q && cnt_q != '0 |-> rem_q < {1'b0, div_q},
               "partial remainder out of range")

endmodule

/* src/cpsm_regs.sv */
// APB register block: speed numerator and idle timeout.
// Depends on cpsm_pkg.
module cpsm_regs import cpsm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_numerator <= NUM_RESET;
      cfg_q.timeout_ticks   <= TIMEOUT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_NUMERATOR: cfg_q.speed_numerator <= pwdata[NUM_W-1:0];
        REG_TIMEOUT:   cfg_q.timeout_ticks   <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUMERATOR: prdata = {{(APB_DW-NUM_W){1'b0}}, cfg_q.speed_numerator};
      REG_TIMEOUT:   prdata = {{(APB_DW-TMO_W){1'b0}}, cfg_q.timeout_ticks};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* test/tb_capture_period_speed_meter.sv */
// Self-checking testbench for capture_period_speed_meter: directed and random
// capture/tick traffic, speed results checked against an in-bench predictor.
// Depends on cpsm_pkg, cpsm_in_if / cpsm_out_if and the RTL top level.
module tb_capture_period_speed_meter import cpsm_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;  // longer than one capture in flight
  localparam int IDLE_PCT     = 17;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      slot;
    logic                      from_timeout;
    logic                      clipped;
  } speed_result_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  cpsm_in_if  in_bus ();
  cpsm_out_if out_bus ();

  capture_period_speed_meter dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state and register copies
  logic [NUM_W-1:0] cfg_num;
  logic [TMO_W-1:0] cfg_tmo;
  logic [CAP_W-1:0] last_capture;
  logic             slot_ptr;
  logic [TMO_W-1:0] idle_ticks;

  speed_result_t expected_speeds[$];
  int            mismatch_count;
  bit            idling_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Expected result of one accepted item, if it causes one.
  task automatic predict_speed(input logic kind, input logic [CAP_W-1:0] cap,
                               input logic rev);
    logic [CAP_W-1:0] diff;
    logic [CAP_W-1:0] mag;
    speed_result_t    r;
    r = '0;
    if (kind == REQ_CAPTURE) begin
      diff = cap - last_capture;
      last_capture = cap;
      mag = '0;
      if (diff != '0) begin
        mag = {8'd0, cfg_num} / diff;
        if (mag > {17'd0, SPEED_MAX}) begin
          mag = {17'd0, SPEED_MAX};
          r.clipped = 1'b1;
        end
      end
      r.speed = rev ? (16'd0 - mag[15:0]) : mag[15:0];
      r.slot = slot_ptr;
      slot_ptr = ~slot_ptr;
      idle_ticks = '0;
      expected_speeds.push_back(r);
    end else begin
      if (idle_ticks != '1) idle_ticks++;
      if (idle_ticks > cfg_tmo) begin
        r.slot = slot_ptr;
        r.from_timeout = 1'b1;
        slot_ptr = ~slot_ptr;
        idle_ticks = '0;
        expected_speeds.push_back(r);
      end
    end
  endtask

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_item(input logic kind, input logic [CAP_W-1:0] cap, input logic rev);
    if (idling_on && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_bus.valid             <= 1'b1;
    in_bus.req_type          <= kind;
    in_bus.capture_value     <= cap;
    in_bus.direction_reverse <= rev;
    do @(posedge clk); while (!in_bus.ready);
    predict_speed(kind, cap, rev);
    @(negedge clk);
  endtask

  task automatic send_capture(input logic [CAP_W-1:0] cap, input logic rev);
    send_item(REQ_CAPTURE, cap, rev);
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, $urandom, 1'($urandom_range(1)));
  endtask

  // Stop sending and let the block go quiet.
  task automatic wait_results_done();
    in_bus.valid <= 1'b0;
    while (expected_speeds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic idx, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_register(input logic idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] rd;
    logic [APB_DW-1:0] want;
    wait_results_done();
    apb_transfer(1'b1, idx, value, rd);
    if (idx == REG_NUMERATOR) cfg_num = value[NUM_W-1:0];
    else cfg_tmo = value[TMO_W-1:0];
    apb_transfer(1'b0, idx, '0, rd);
    want = (idx == REG_NUMERATOR) ? APB_DW'(cfg_num) : APB_DW'(cfg_tmo);
    if (rd !== want) report_mismatch("register readback", rd, want);
  endtask

  always @(negedge clk) begin
    out_bus.ready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    speed_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_speeds.size() == 0) begin
        report_mismatch("unexpected result, speed", out_bus.speed_mrev_s, 0);
      end else begin
        want = expected_speeds.pop_front();
        if (out_bus.speed_mrev_s !== want.speed)
          report_mismatch("speed_mrev_s", out_bus.speed_mrev_s, want.speed);
        if (out_bus.slot_index !== want.slot)
          report_mismatch("slot_index", out_bus.slot_index, want.slot);
        if (out_bus.from_timeout !== want.from_timeout)
          report_mismatch("from_timeout", out_bus.from_timeout, want.from_timeout);
        if (out_bus.clipped !== want.clipped)
          report_mismatch("clipped", out_bus.clipped, want.clipped);
      end
    end
  end

  task automatic test_reset_values();
    logic [APB_DW-1:0] rd;
    apb_transfer(1'b0, REG_NUMERATOR, '0, rd);
    if (rd !== APB_DW'(NUM_RESET)) report_mismatch("numerator after reset", rd, NUM_RESET);
    apb_transfer(1'b0, REG_TIMEOUT, '0, rd);
    if (rd !== APB_DW'(TIMEOUT_RESET)) report_mismatch("timeout after reset", rd, TIMEOUT_RESET);
  endtask

  task automatic test_capture_cases();
    send_capture(32'd100, 1'b0);           // first capture counts from zero
    send_capture(32'd100, 1'b1);           // zero period, reverse
    send_capture(32'd101, 1'b0);           // period 1 saturates
    send_capture(32'd102, 1'b1);           // saturated reverse
    send_capture(32'hFFFF_FFF0, 1'b0);     // huge period gives zero
    send_capture(32'h0000_0010, 1'b1);     // counter wrap
    send_capture(32'hFFFF_FFFF, 1'b0);
    send_capture(32'h0000_0000, 1'b0);     // wrap by one count
  endtask

  task automatic test_timeout_cases();
    set_register(REG_TIMEOUT, 32'd0);      // every tick fires
    send_tick();
    send_tick();
    set_register(REG_TIMEOUT, 32'd2);
    send_tick();
    send_tick();
    send_capture(last_capture + 32'd1000, 1'b0);  // clears idle time
    send_tick();
    send_tick();
    send_tick();
    set_register(REG_TIMEOUT, 32'hFFFF_FFFF);     // upper bits dropped; never fires
    send_tick();
    send_tick();
    send_tick();
  endtask

  task automatic test_numerator_cases();
    set_register(REG_NUMERATOR, 32'd0);
    send_capture(last_capture + 32'd5, 1'b0);
    send_capture(last_capture + 32'd1, 1'b1);
    set_register(REG_NUMERATOR, 32'hFFFF_FFFF);   // masks to full scale
    send_capture(last_capture + 32'd1, 1'b0);
    send_capture(last_capture + 32'h200, 1'b1);   // just below saturation
    send_capture(last_capture + 32'h1FF, 1'b0);   // just above
    set_register(REG_NUMERATOR, 32'd1);
  endtask

  task automatic run_random_phase(input int items, input bit pause_midway);
    int               sent;
    int               burst;
    int               lim;
    logic [CAP_W-1:0] diff;
    logic [CAP_W-1:0] thr;
    bit               paused;
    sent = 0;
    paused = 1'b0;
    while (sent < items) begin
      if (pause_midway && !paused && sent >= items / 2) begin
        wait_results_done();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 30) begin
        // tick runs long enough to cross the timeout now and then
        lim = (cfg_tmo > 20) ? 8 : int'(cfg_tmo) + 3;
        burst = $urandom_range(1, lim);
        repeat (burst) send_tick();
        sent += burst;
      end else begin
        thr = {8'd0, cfg_num} / 32'd32767;
        case ($urandom_range(5))
          0: diff = '0;
          1: diff = $urandom_range(1, 16);
          2: diff = thr + $urandom_range(0, 4) - 32'd2;   // around the clip edge
          3: diff = $urandom_range(1, 1 << 20);
          4: diff = $urandom;
          default: diff = $urandom - last_capture;       // arbitrary absolute value
        endcase
        send_capture(last_capture + diff, 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    set_register(REG_NUMERATOR, 32'd240000);
    set_register(REG_TIMEOUT, $urandom_range(1, 8));
    run_random_phase(180, 1'b0);

    idling_on = 1'b0;
    set_register(REG_NUMERATOR, $urandom_range(1, 24'hFF_FFFF));
    set_register(REG_TIMEOUT, $urandom_range(1, 30));
    run_random_phase(180, 1'b0);
    idling_on = 1'b1;

    set_register(REG_NUMERATOR, 32'h00FF_FFFF);
    set_register(REG_TIMEOUT, 32'd1);
    run_random_phase(180, 1'b1);

    set_register(REG_NUMERATOR, 32'd1);
    set_register(REG_TIMEOUT, 32'd65534);
    run_random_phase(180, 1'b0);

    set_register(REG_NUMERATOR, $urandom_range(1, 5000));
    set_register(REG_TIMEOUT, $urandom_range(1, 16));
    run_random_phase(180, 1'b0);
  endtask

  initial begin
    rst_n                    = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    in_bus.valid             = 1'b0;
    in_bus.req_type          = REQ_CAPTURE;
    in_bus.capture_value     = '0;
    in_bus.direction_reverse = 1'b0;
    out_bus.ready            = 1'b0;
    mismatch_count           = 0;
    idling_on                = 1'b1;
    cfg_num                  = NUM_RESET;
    cfg_tmo                  = TIMEOUT_RESET;
    last_capture             = '0;
    slot_ptr                 = 1'b0;
    idle_ticks               = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_values();
    test_capture_cases();
    test_timeout_cases();
    test_numerator_cases();
    test_random_traffic();

    wait_results_done();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
